// File: hw/rtl/encoder_pulse_speed_meter_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef ENCODER_PULSE_SPEED_METER_UNIT_DEFINES_SVH
`define ENCODER_PULSE_SPEED_METER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define EPSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is held.
`define EPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/epsm_pkg.sv
package epsm_pkg;

    // Item kinds
    localparam logic [1:0] KIND_PULSE  = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MIN_INTERVAL    = 1'b0;
    localparam logic CFG_PULSES_PER_TURN = 1'b1;

    localparam logic [15:0] MIN_INTERVAL_RESET    = 16'd50;
    localparam logic [7:0]  PULSES_PER_TURN_RESET = 8'd11;

    // Field widths fixed by the interface
    localparam int MASK_W  = 2;
    localparam int COUNT_W = 32;
    localparam int SPEED_W = 16;

    // Scale factors
    localparam logic [9:0] SPEED_SCALE = 10'd1000;
    localparam logic [5:0] RPM_SCALE   = 6'd60;

    // Shared divider geometry
    localparam int NUM_W     = 42;
    localparam int DEN_W     = 32;
    localparam int ITER_W    = 6;
    localparam int RPM_NUM_W = 21;
    localparam logic [ITER_W-1:0] SPEED_ITERS = 6'd42;
    localparam logic [ITER_W-1:0] RPM_ITERS   = 6'd21;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_UPD_CHK = 8'b0000_0010,
        ST_UPD_MUL = 8'b0000_0100,
        ST_UPD_DIV = 8'b0000_1000,
        ST_UPD_SAT = 8'b0001_0000,
        ST_RPM_MUL = 8'b0010_0000,
        ST_RPM_DIV = 8'b0100_0000,
        ST_RPT_OUT = 8'b1000_0000
    } state_t;

endpackage

// File: hw/rtl/encoder_pulse_speed_meter_unit.sv
// Encoder pulse counter and speed meter for CHANNELS channels. Each accepted item
// (pulse mask, speed update at a millisecond time stamp, or channel clear) produces
// one result per channel, channel 0 first, with last set on the final one. Items are
// handled one at a time and s_ready stays low until the last result of the item has
// been placed in the output register; a stalled result side holds the item up. A
// speed update recomputes speed only for channels whose interval has run out. The
// single shared radix-2 divider takes 42 steps for each speed quotient and 21 steps
// for each RPM quotient. Speed is (count change * 1000) / elapsed ms, truncated toward
// zero and saturated to 16-bit signed; RPM is |speed| * 60 / pulses_per_turn,
// saturated to 65535. Configuration index 0 is min_interval_ms (16 bit), index 1 is
// pulses_per_turn (low 8 bits); a zero in either acts as one.
module encoder_pulse_speed_meter_unit #(
    parameter int CHANNELS = 2
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [1:0]         s_pulse_mask,
    input  logic [31:0]        s_now_ms,
    input  logic               s_channel,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_report_channel,
    output logic signed [31:0] m_pulse_total,
    output logic signed [15:0] m_pulses_per_second,
    output logic [15:0]        m_turns_per_minute,
    output logic               m_last,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);
    import epsm_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration
    logic [15:0] min_interval_reg;
    logic [7:0]  ppt_reg;

    // Per-channel state
    logic [COUNT_W-1:0] count_now_reg [CHANNELS];
    logic [COUNT_W-1:0] count_at_reg  [CHANNELS];
    logic [31:0]        time_at_reg   [CHANNELS];
    logic [SPEED_W-1:0] speed_reg     [CHANNELS];

    // Sequencer
    state_t            state_reg, state_next;
    logic [CH_W-1:0]   chan_reg, chan_next;
    logic [31:0]       now_reg;
    logic              neg_reg;
    logic [COUNT_W-1:0] dc_mag_reg;
    logic [31:0]       dt_reg;

    // Output register
    logic               m_valid_reg;
    logic               out_chan_reg;
    logic [COUNT_W-1:0] out_total_reg;
    logic [SPEED_W-1:0] out_speed_reg;
    logic [15:0]        out_rpm_reg;
    logic               out_last_reg;

    logic [CHANNELS-1:0] hit;
    logic                s_xfer;
    logic                slot_free;
    logic                chan_last;
    logic [31:0]         dt;
    logic [15:0]         min_eff;
    logic                due;
    logic [COUNT_W-1:0]  diff;
    logic [COUNT_W-1:0]  diff_mag;
    logic [NUM_W-1:0]    speed_prod;
    logic [SPEED_W-1:0]  spd;
    logic [SPEED_W:0]    spd_mag;
    logic [RPM_NUM_W-1:0] rpm_prod;
    logic [7:0]          ppt_eff;
    logic [NUM_W-1:0]    quo;
    logic [SPEED_W-1:0]  speed_sat;
    logic [15:0]         rpm_sat;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // Mask bits beyond the mask field never reach a channel
    for (genvar g = 0; g < CHANNELS; g++) begin : g_hit
        assign hit[g] = (g < MASK_W) ? s_pulse_mask[g % MASK_W] : 1'b0;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign chan_last = (chan_reg == CH_W'(CHANNELS - 1));
    assign cfg_ready = 1'b1;

    // Interval check for the selected channel
    assign min_eff = (min_interval_reg == 16'd0) ? 16'd1 : min_interval_reg;
    assign dt      = now_reg - time_at_reg[chan_reg];
    assign due     = (dt >= {16'd0, min_eff});

    // Count change as sign and magnitude
    assign diff     = count_now_reg[chan_reg] - count_at_reg[chan_reg];
    assign diff_mag = diff[COUNT_W-1] ? (COUNT_W'(0) - diff) : diff;

    assign speed_prod = NUM_W'(dc_mag_reg) * NUM_W'(SPEED_SCALE);

    // RPM numerator from the held speed
    assign spd      = speed_reg[chan_reg];
    assign spd_mag  = spd[SPEED_W-1] ? ((SPEED_W+1)'(0) - {spd[SPEED_W-1], spd})
                                     : {1'b0, spd};
    assign rpm_prod = RPM_NUM_W'(spd_mag) * RPM_NUM_W'(RPM_SCALE);
    assign ppt_eff  = (ppt_reg == 8'd0) ? 8'd1 : ppt_reg;

    // Feed the shared divider
    always_comb begin
        div_req.start = (state_reg == ST_UPD_MUL) || (state_reg == ST_RPM_MUL);
        if (state_reg == ST_UPD_MUL) begin
            div_req.iters = SPEED_ITERS;
            div_req.num   = speed_prod;
            div_req.den   = dt_reg;
        end else begin
            div_req.iters = RPM_ITERS;
            div_req.num   = {rpm_prod, (NUM_W-RPM_NUM_W)'(0)};
            div_req.den   = DEN_W'(ppt_eff);
        end
    end

    epsm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign quo = div_rsp.quo;

    // Saturate the speed quotient and restore its sign
    always_comb begin
        if (neg_reg) begin
            if (quo > NUM_W'(32768)) begin
                speed_sat = 16'h8000;
            end else begin
                speed_sat = 16'd0 - quo[15:0];
            end
        end else begin
            if (quo > NUM_W'(32767)) begin
                speed_sat = 16'h7fff;
            end else begin
                speed_sat = quo[15:0];
            end
        end
    end

    assign rpm_sat = (quo[RPM_NUM_W-1:0] > RPM_NUM_W'(65535)) ? 16'hffff : quo[15:0];

    // Next state and channel
    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    chan_next  = '0;
                    state_next = (s_kind == KIND_UPDATE) ? ST_UPD_CHK : ST_RPM_MUL;
                end
            end
            ST_UPD_CHK: begin
                if (due) begin
                    state_next = ST_UPD_MUL;
                end else if (chan_last) begin
                    chan_next  = '0;
                    state_next = ST_RPM_MUL;
                end else begin
                    chan_next = chan_reg + CH_W'(1);
                end
            end
            ST_UPD_MUL: begin
                state_next = ST_UPD_DIV;
            end
            ST_UPD_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_UPD_SAT;
                end
            end
            ST_UPD_SAT: begin
                if (chan_last) begin
                    chan_next  = '0;
                    state_next = ST_RPM_MUL;
                end else begin
                    chan_next  = chan_reg + CH_W'(1);
                    state_next = ST_UPD_CHK;
                end
            end
            ST_RPM_MUL: begin
                state_next = ST_RPM_DIV;
            end
            ST_RPM_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_RPT_OUT;
                end
            end
            ST_RPT_OUT: begin
                if (slot_free) begin
                    if (chan_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        chan_next  = chan_reg + CH_W'(1);
                        state_next = ST_RPM_MUL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            chan_reg         <= '0;
            min_interval_reg <= MIN_INTERVAL_RESET;
            ppt_reg          <= PULSES_PER_TURN_RESET;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MIN_INTERVAL) begin
                    min_interval_reg <= cfg_data;
                end else begin
                    ppt_reg <= cfg_data[7:0];
                end
            end
        end
    end

    // Per-channel state: pulses and clears on transfer, latch on speed update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                count_now_reg[c] <= '0;
                count_at_reg[c]  <= '0;
                time_at_reg[c]   <= '0;
                speed_reg[c]     <= '0;
            end
        end else begin
            if (s_xfer && (s_kind == KIND_PULSE)) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (hit[c]) begin
                        count_now_reg[c] <= count_now_reg[c] + COUNT_W'(1);
                    end
                end
            end
            if (s_xfer && (s_kind == KIND_CLEAR)) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (32'(s_channel) == 32'(c)) begin
                        count_now_reg[c] <= '0;
                        count_at_reg[c]  <= '0;
                        time_at_reg[c]   <= '0;
                        speed_reg[c]     <= '0;
                    end
                end
            end
            if (state_reg == ST_UPD_SAT) begin
                speed_reg[chan_reg]    <= speed_sat;
                count_at_reg[chan_reg] <= count_now_reg[chan_reg];
                time_at_reg[chan_reg]  <= now_reg;
            end
        end
    end

    // Item time stamp and speed operands
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            now_reg <= s_now_ms;
        end
        if (state_reg == ST_UPD_CHK) begin
            neg_reg    <= diff[COUNT_W-1];
            dc_mag_reg <= diff_mag;
            dt_reg     <= dt;
        end
    end

    // Output register: load a result when the slot is free, drop valid on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_RPT_OUT) && slot_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_RPT_OUT) && slot_free) begin
            out_chan_reg  <= chan_reg[0];
            out_total_reg <= count_now_reg[chan_reg];
            out_speed_reg <= spd;
            out_rpm_reg   <= rpm_sat;
            out_last_reg  <= chan_last;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_report_channel    = out_chan_reg;
    assign m_pulse_total       = $signed(out_total_reg);
    assign m_pulses_per_second = $signed(out_speed_reg);
    assign m_turns_per_minute  = out_rpm_reg;
    assign m_last              = out_last_reg;

endmodule

// File: hw/rtl/epsm_div.sv
module epsm_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  epsm_pkg::div_req_t req,
    output epsm_pkg::div_rsp_t rsp
);
    import epsm_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W+1:0]  trial;
    logic              borrow;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial  = {1'b0, rem_reg, num_reg[NUM_W-1]} - {2'b00, den_reg};
    assign borrow = trial[DEN_W+1];

    // Control: one quotient bit per cycle, pulse done after the final bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == ITER_W'(1));
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - ITER_W'(1);
                if (cnt_reg == ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: restoring division, quotient bits shift in at the bottom
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], ~borrow};
            if (!borrow) begin
                rem_reg <= trial[DEN_W-1:0];
            end else begin
                rem_reg <= {rem_reg[DEN_W-2:0], num_reg[NUM_W-1]};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

// File: hw/rtl/epsm_checker.sv
`include "encoder_pulse_speed_meter_unit_defines.svh"

module epsm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_last,
    input logic signed [31:0] m_pulse_total,
    input logic signed [15:0] m_pulses_per_second,
    input logic [15:0]        m_turns_per_minute
);

    // A stalled result holds its count
    `EPSM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_pulse_total), "result changed while stalled")

    // Ready is low in the cycle after an item is taken
    `EPSM_ASSERT_NEXT(a_busy_after_in, s_valid && s_ready, !s_ready, "ready straight after a transfer")

    // While a result other than the final one waits, the item is still in work
    `EPSM_ASSERT_NOW(a_no_overlap, m_valid && !m_last, !s_ready, "ready before the item finished")

    // Zero speed means zero RPM
    `EPSM_ASSERT_NOW(a_rpm_zero, m_valid && (m_pulses_per_second == 16'sd0), m_turns_per_minute == 16'd0, "RPM without speed")

endmodule

bind encoder_pulse_speed_meter_unit epsm_checker u_epsm_checker (.*);
